@@ hw/rtl/fpsf_pkg.sv @@
// Shared widths, register indexes and the half-step phase pattern table.
package fpsf_pkg;

	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned POS_W      = COUNT_W + FRAC_W;
	localparam int unsigned SPEED_W    = 24;
	localparam int unsigned DUTY_W     = 16;
	localparam int unsigned POINT_W    = SPEED_W + DUTY_W;
	localparam int unsigned PHASE_W    = 4;
	localparam int unsigned PHASES     = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned TABLE_REGS = 6;
	localparam int unsigned PT_IDX_W   = $clog2(TABLE_REGS);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_LAST  = 3'd6;

	// Half-step index range.
	localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd0;
	localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd9;
	localparam int unsigned        PHASE_STATES = 10;

	typedef logic [PHASES-1:0] phase_mask_t;

	// Bit 0 is phase A, bit 4 is phase E.
	localparam phase_mask_t PHASE_PATTERN [PHASE_STATES] = '{
		5'b00011, 5'b00010, 5'b00110, 5'b00100, 5'b01100,
		5'b01000, 5'b11000, 5'b10000, 5'b10001, 5'b00001
	};

	// Integer part of a Q32.16 value, truncated toward zero.
	function automatic logic signed [COUNT_W-1:0] trunc_int(input logic signed [POS_W-1:0] x);
		logic signed [COUNT_W-1:0] fl;
		fl = x[POS_W-1:FRAC_W];
		if (x[POS_W-1] && (x[FRAC_W-1:0] != '0)) begin
			return fl + 32'sd1;
		end
		return fl;
	endfunction

endpackage

@@ hw/rtl/fpsf_if.sv @@
// Valid/ready channel interfaces for command words, result words and register writes.
interface fpsf_item_if import fpsf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COUNT_W-1:0] target_count;

	modport source (output valid, output target_count, input ready);
	modport sink (input valid, input target_count, output ready);
endinterface

interface fpsf_result_if import fpsf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COUNT_W-1:0] position;
	logic [PHASE_W-1:0]        phase_index;
	logic [DUTY_W-1:0]         duty_a;
	logic [DUTY_W-1:0]         duty_b;
	logic [DUTY_W-1:0]         duty_c;
	logic [DUTY_W-1:0]         duty_d;
	logic [DUTY_W-1:0]         duty_e;

	modport source (output valid, output position, output phase_index, output duty_a,
		output duty_b, output duty_c, output duty_d, output duty_e, input ready);
	modport sink (input valid, input position, input phase_index, input duty_a,
		input duty_b, input duty_c, input duty_d, input duty_e, output ready);
endinterface

interface fpsf_cfg_if import fpsf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [POINT_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/five_phase_stepper_follower.sv @@
// An accepted command word runs through the move, clamp and update states and the curve search;
// an interpolated duty then adds the multiply, a bit-serial divider and the final add before
// the result word is loaded, and a stalled result sink holds it in the output state. The curve
// search walks one point a cycle. A new command word is taken only once the
// previous one is loaded as a result word, and may be taken while the previous
// result word still waits. Reset (arst_n low) clears the position, the half-step index and
// the configuration registers at once; no clearing pass follows.
module five_phase_stepper_follower import fpsf_pkg::*; #(
	parameter int unsigned CURVE_POINTS = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	fpsf_item_if.sink      item,
	fpsf_result_if.source  result,
	fpsf_cfg_if.sink       cfg
);

	localparam logic [PT_IDX_W-1:0] LAST_PT = PT_IDX_W'(CURVE_POINTS - 1);
	localparam int unsigned DIV_STEPS = 16;
	localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MOVE, S_CLAMP, S_UPDATE, S_SEARCH, S_MUL, S_DIV, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [SPEED_W-1:0] step_limit_q;
	logic [POINT_W-1:0] point_q [TABLE_REGS];

	// Persistent follower state.
	logic signed [POS_W-1:0] tp_q;
	logic [PHASE_W-1:0]      idx_q;

	// Working registers.
	logic signed [POS_W-1:0]   target_q;
	logic signed [POS_W:0]     diff_q;
	logic [SPEED_W-1:0]        lim_q;
	logic signed [SPEED_W:0]   d_q;
	logic [SPEED_W-1:0]        s_q;
	logic signed [COUNT_W-1:0] new_int_q;
	logic [PT_IDX_W-1:0]       k_q;
	logic [SPEED_W-1:0]        prev_sp_q;
	logic [DUTY_W-1:0]         prev_du_q;
	logic [SPEED_W-1:0]        dx_q;
	logic [SPEED_W-1:0]        ds_q;
	logic signed [DUTY_W:0]    dy_q;
	logic [DUTY_W-1:0]         y1_q;
	logic                      neg_q;
	logic [SPEED_W-1:0]        rem_q;
	logic [DUTY_W-1:0]         dvd_q;
	logic [DUTY_W-1:0]         quo_q;
	logic [3:0]                cnt_q;
	logic [DUTY_W-1:0]         duty_q;

	// Result register.
	logic                      res_valid_q;
	logic signed [COUNT_W-1:0] res_pos_q;
	logic [PHASE_W-1:0]        res_phase_q;
	logic [DUTY_W-1:0]         res_duty_q [PHASES];

	// Combinational helpers.
	logic [POINT_W-1:0]        pt_cur;
	logic [SPEED_W-1:0]        pt_sp;
	logic [DUTY_W-1:0]         pt_du;
	logic [SPEED_W-1:0]        last_sp;
	logic signed [POS_W-1:0]   tp_next;
	logic signed [COUNT_W-1:0] old_int;
	logic signed [COUNT_W-1:0] new_int;
	logic signed [POS_W:0]     lim_pos;
	logic signed [POS_W:0]     lim_neg;
	logic [DUTY_W-1:0]         dy_mag;
	logic [POINT_W-1:0]        prod;
	logic [SPEED_W:0]          trial;
	logic                      trial_ge;
	logic                      item_acc;
	logic                      out_free;
	phase_mask_t               pat;

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_acc   = item.valid && item.ready;
	assign out_free   = !res_valid_q || result.ready;

	assign result.valid       = res_valid_q;
	assign result.position    = res_pos_q;
	assign result.phase_index = res_phase_q;
	assign result.duty_a      = res_duty_q[0];
	assign result.duty_b      = res_duty_q[1];
	assign result.duty_c      = res_duty_q[2];
	assign result.duty_d      = res_duty_q[3];
	assign result.duty_e      = res_duty_q[4];

	// Curve point under the search pointer and the last used point's speed.
	assign pt_cur  = point_q[k_q];
	assign pt_sp   = pt_cur[POINT_W-1:DUTY_W];
	assign pt_du   = pt_cur[DUTY_W-1:0];
	assign last_sp = point_q[LAST_PT][POINT_W-1:DUTY_W];

	// Position update and integer-part change detection.
	assign tp_next = tp_q + POS_W'(d_q);
	assign old_int = trunc_int(tp_q);
	assign new_int = trunc_int(tp_next);

	// Clamp bounds.
	assign lim_pos = $signed({{(POS_W + 1 - SPEED_W){1'b0}}, lim_q});
	assign lim_neg = -lim_pos;

	// Multiplier for the interpolation numerator.
	assign dy_mag = dy_q[DUTY_W] ? DUTY_W'(-dy_q) : DUTY_W'(dy_q);
	assign prod   = POINT_W'(dy_mag) * POINT_W'(ds_q);

	// One restoring divider step.
	assign trial    = {rem_q, dvd_q[DUTY_W-1]};
	assign trial_ge = (trial >= {1'b0, dx_q});

	assign pat = PHASE_PATTERN[idx_q];

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= '0;
			for (int i = 0; i < TABLE_REGS; i++) begin
				point_q[i] <= '0;
			end
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_STEP_LIMIT) begin
				step_limit_q <= cfg.data[SPEED_W-1:0];
			end else if (cfg.index >= REG_POINT_FIRST && cfg.index <= REG_POINT_LAST) begin
				point_q[PT_IDX_W'(cfg.index - REG_POINT_FIRST)] <= cfg.data;
			end
		end
	end

	// Sequencer, follower state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tp_q        <= '0;
			idx_q       <= PHASE_FIRST;
			k_q         <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// A result word is loaded when the output register is free and held until taken.
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					tp_q <= tp_next;
					if (old_int != new_int) begin
						if (d_q[SPEED_W]) begin
							idx_q <= (idx_q == PHASE_FIRST) ? PHASE_LAST : idx_q - 4'd1;
						end else begin
							idx_q <= (idx_q >= PHASE_LAST) ? PHASE_FIRST : idx_q + 4'd1;
						end
					end
					k_q     <= '0;
					state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					if (s_q < pt_sp) begin
						state_q <= (k_q == '0) ? S_OUT : S_MUL;
					end else if (k_q == LAST_PT) begin
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + PT_IDX_W'(1);
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					target_q <= {item.target_count, {FRAC_W{1'b0}}};
				end
			end
			S_MOVE: begin
				diff_q <= (POS_W + 1)'(target_q) - (POS_W + 1)'(tp_q);
				lim_q  <= (step_limit_q > last_sp) ? last_sp : step_limit_q;
			end
			S_CLAMP: begin
				if (diff_q > lim_pos) begin
					d_q <= (SPEED_W + 1)'(lim_pos);
				end else if (diff_q < lim_neg) begin
					d_q <= (SPEED_W + 1)'(lim_neg);
				end else begin
					d_q <= diff_q[SPEED_W:0];
				end
			end
			S_UPDATE: begin
				new_int_q <= new_int;
				s_q       <= d_q[SPEED_W] ? SPEED_W'(-d_q) : SPEED_W'(d_q);
			end
			S_SEARCH: begin
				if (s_q < pt_sp) begin
					duty_q <= pt_du;
					dx_q   <= pt_sp - prev_sp_q;
					ds_q   <= s_q - prev_sp_q;
					dy_q   <= $signed({1'b0, pt_du}) - $signed({1'b0, prev_du_q});
					y1_q   <= prev_du_q;
				end else begin
					duty_q    <= pt_du;
					prev_sp_q <= pt_sp;
					prev_du_q <= pt_du;
				end
			end
			S_MUL: begin
				rem_q <= prod[POINT_W-1:DUTY_W];
				dvd_q <= prod[DUTY_W-1:0];
				quo_q <= '0;
				neg_q <= dy_q[DUTY_W];
			end
			S_DIV: begin
				rem_q <= trial_ge ? SPEED_W'(trial - {1'b0, dx_q}) : trial[SPEED_W-1:0];
				quo_q <= {quo_q[DUTY_W-2:0], trial_ge};
				dvd_q <= {dvd_q[DUTY_W-2:0], 1'b0};
			end
			S_FIN: begin
				duty_q <= neg_q ? (y1_q - quo_q) : (y1_q + quo_q);
			end
			S_OUT: begin
				if (out_free) begin
					res_pos_q   <= new_int_q;
					res_phase_q <= idx_q;
					for (int j = 0; j < PHASES; j++) begin
						res_duty_q[j] <= pat[j] ? duty_q : '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The move applied to the position never exceeds the effective limit.
	a_move_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) |-> ((d_q <= $signed({1'b0, lim_q}))
			&& (d_q >= -$signed({1'b0, lim_q}))))
		else $error("move exceeds step limit");

	// The divider remainder stays below the segment width.
	a_rem_below_dx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dx_q))
		else $error("divider remainder out of range");

	// The half-step index stays within its ten states.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= PHASE_LAST)
		else $error("half-step index out of range");

	// Ready is low right after a command word is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> !item.ready)
		else $error("command taken while busy");

	// The index moves by at most one step per command word.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_UPDATE) |=> $stable(idx_q))
		else $error("half-step index changed outside update");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the five-phase stepper follower: directed and random ticks.
module tb_top import fpsf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CLK_PERIOD     = 4;
	localparam int     TIMEOUT_CYCLES = 300_000;
	localparam int     CURVE_POINTS   = 6;
	localparam longint FRAC_ONE       = 65536;
	localparam int     MAX_REPORTS    = 10;

	// Index past the last curve point; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 3'd7;

	typedef logic [POINT_W-1:0] curve_t [TABLE_REGS];

	typedef struct packed {
		logic signed [COUNT_W-1:0]        position;
		logic [PHASE_W-1:0]               phase_index;
		logic [PHASES-1:0][DUTY_W-1:0]    duty;
	} tick_t;

	// Phases that are energized in each half-step state, phase A in bit 0.
	localparam logic [PHASES-1:0] PHASES_ON [PHASE_STATES] = '{
		5'b00011, 5'b00010, 5'b00110, 5'b00100, 5'b01100,
		5'b01000, 5'b11000, 5'b10000, 5'b10001, 5'b00001
	};

	// Ascending curve with a falling segment, used by the directed tests.
	localparam curve_t RAMP_CURVE = '{
		{24'h004000, 16'h1000}, {24'h010000, 16'h3000}, {24'h020000, 16'h2000},
		{24'h040000, 16'h8000}, {24'h080000, 16'hC000}, {24'h100000, 16'hFFFF}
	};

	localparam curve_t EXTREME_CURVE = '{
		{24'h000001, 16'hFFFF}, {24'h000002, 16'h0000}, {24'h3FFFFF, 16'hFFFF},
		{24'h7FFFFF, 16'h0000}, {24'hFFFFFE, 16'hFFFF}, {24'hFFFFFF, 16'hFFFF}
	};

	localparam curve_t ZERO_CURVE = '{default: '0};

	logic clk = 1'b0;
	logic arst_n;

	fpsf_item_if   item_ch ();
	fpsf_result_if result_ch ();
	fpsf_cfg_if    cfg_ch ();

	five_phase_stepper_follower #(
		.CURVE_POINTS(CURVE_POINTS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// Follower state and register copies kept by the predictor.
	longint             tracked_pos = 0;
	logic [PHASE_W-1:0] step_phase  = PHASE_FIRST;
	logic [SPEED_W-1:0] limit_reg   = '0;
	logic [POINT_W-1:0] curve_reg [TABLE_REGS] = '{default: '0};

	tick_t expected_ticks [$];
	int    fail_count = 0;
	bit    idle_on    = 1'b1;

	function automatic longint point_speed(input int k);
		return longint'(curve_reg[k][POINT_W-1:DUTY_W]);
	endfunction

	function automatic longint point_duty(input int k);
		return longint'(curve_reg[k][DUTY_W-1:0]);
	endfunction

	// Piecewise-linear duty for a per-tick speed magnitude.
	function automatic logic [DUTY_W-1:0] curve_duty(input longint speed);
		int                 i;
		longint             x1, x2, y1, y2, num, mag;
		logic [DUTY_W-1:0]  duty;
		i = 0;
		while (i < CURVE_POINTS && speed >= point_speed(i))
			i++;
		if (i == 0) begin
			duty = DUTY_W'(point_duty(0));
		end else if (i >= CURVE_POINTS) begin
			duty = DUTY_W'(point_duty(CURVE_POINTS - 1));
		end else begin
			x1 = point_speed(i - 1);
			x2 = point_speed(i);
			y1 = point_duty(i - 1);
			y2 = point_duty(i);
			num = (y2 - y1) * (speed - x1);
			mag = (num < 0 ? -num : num) / (x2 - x1);
			duty = DUTY_W'(y1 + (num < 0 ? -mag : mag));
		end
		return duty;
	endfunction

	function automatic longint effective_limit();
		longint lim;
		lim = limit_reg;
		if (lim > point_speed(CURVE_POINTS - 1))
			lim = point_speed(CURVE_POINTS - 1);
		return lim;
	endfunction

	// Advances the follower by one tick and returns the result word it should give.
	function automatic tick_t predict_tick(input logic signed [COUNT_W-1:0] target);
		longint            tgt, lim, move, old_int, new_int, speed;
		logic [DUTY_W-1:0] duty;
		tick_t             r;
		int                p;
		tgt = longint'(target) * FRAC_ONE;
		lim = effective_limit();
		move = tgt - tracked_pos;
		if (move > lim)
			move = lim;
		else if (move < -lim)
			move = -lim;
		old_int = tracked_pos / FRAC_ONE;
		tracked_pos += move;
		new_int = tracked_pos / FRAC_ONE;
		// The half-step index follows each change of the whole-step count.
		if (old_int != new_int) begin
			if (move >= 0)
				step_phase = (step_phase == PHASE_LAST) ? PHASE_FIRST : step_phase + 4'd1;
			else
				step_phase = (step_phase == PHASE_FIRST) ? PHASE_LAST : step_phase - 4'd1;
		end
		speed = move < 0 ? -move : move;
		duty = curve_duty(speed);
		r.position = new_int[COUNT_W-1:0];
		r.phase_index = step_phase;
		for (p = 0; p < PHASES; p++)
			r.duty[p] = PHASES_ON[step_phase][p] ? duty : '0;
		return r;
	endfunction

	// Mostly follows the current position, sometimes jumps anywhere.
	function automatic logic signed [COUNT_W-1:0] pick_target();
		longint      here, span;
		int unsigned roll;
		here = tracked_pos / FRAC_ONE;
		roll = $urandom_range(0, 99);
		span = (effective_limit() >> FRAC_W) * 3 + 2;
		if (roll < 15)
			return $urandom;
		if (roll < 25)
			return here[COUNT_W-1:0];
		return COUNT_W'(here + longint'($urandom_range(0, 32'(2 * span))) - span);
	endfunction

	// Sends one command word; valid is left high so words can go back to back.
	task automatic send_target(input logic signed [COUNT_W-1:0] target);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.target_count <= target;
		do @(posedge clk); while (!item_ch.ready);
		expected_ticks.push_back(predict_tick(target));
	endtask

	// Stops sending and waits until every result word has come back.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_ticks.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POINT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_STEP_LIMIT)
			limit_reg = value[SPEED_W-1:0];
		else if (idx >= REG_POINT_FIRST && idx <= REG_POINT_LAST)
			curve_reg[idx - REG_POINT_FIRST] = value;
	endtask

	task automatic load_registers(input logic [SPEED_W-1:0] limit, input curve_t pts);
		int k;
		write_reg(REG_STEP_LIMIT, POINT_W'(limit));
		for (k = 0; k < TABLE_REGS; k++)
			write_reg(REG_POINT_FIRST + k[CFG_IDX_W-1:0], pts[k]);
		cfg_ch.valid <= 1'b0;
	endtask

	// Random curve at one of three speed scales, sorted or in any order.
	task automatic random_registers(input bit sorted);
		curve_t             pts;
		logic [SPEED_W-1:0] sp [TABLE_REGS];
		logic [SPEED_W-1:0] top, swap, lim;
		int                 i, j;
		case ($urandom_range(0, 2))
			0: top = 24'h020000;
			1: top = 24'h100000;
			default: top = 24'hFFFFFF;
		endcase
		for (i = 0; i < TABLE_REGS; i++)
			sp[i] = SPEED_W'($urandom_range(0, top));
		if (sorted) begin
			for (i = 0; i < TABLE_REGS - 1; i++)
				for (j = 0; j < TABLE_REGS - 1 - i; j++)
					if (sp[j] > sp[j + 1]) begin
						swap = sp[j];
						sp[j] = sp[j + 1];
						sp[j + 1] = swap;
					end
		end
		for (i = 0; i < TABLE_REGS; i++)
			pts[i] = {sp[i], 16'($urandom)};
		lim = ($urandom_range(0, 7) == 0) ? '0 : SPEED_W'($urandom_range(0, top));
		load_registers(lim, pts);
	endtask

	// Registers at reset value: nothing moves and every duty is zero.
	task automatic test_reset_state();
		send_target(32'sd0);
		send_target(32'sh7FFF_FFFF);
		send_target(32'sh8000_0000);
		wait_idle();
	endtask

	// Below the first point, exact point, last segment, last point, index wrap both ways.
	task automatic test_curve_segments();
		load_registers(24'h200000, RAMP_CURVE);
		send_target(32'sd0);
		send_target(-32'sd1);
		send_target(32'sd0);
		send_target(32'sd12);
		send_target(32'sd100);
		send_target(32'sh7FFF_FFFF);
		send_target(32'sh8000_0000);
		send_target(32'sd12);
		wait_idle();
	endtask

	// Limit of one and a half steps: fractional positions crossing zero.
	task automatic test_fractional_moves();
		int k;
		load_registers(24'h018000, RAMP_CURVE);
		for (k = 0; k < 10; k++)
			send_target(-32'sd2);
		wait_idle();
	endtask

	// Full-scale limit and curve, then every register back to zero.
	task automatic test_register_extremes();
		load_registers(24'hFFFFFF, EXTREME_CURVE);
		send_target(32'sh7FFF_FFFF);
		send_target(32'sh8000_0000);
		send_target(32'sh8000_0000);
		send_target(32'sh7FFF_FFFF);
		send_target(pick_target());
		wait_idle();
		load_registers('0, ZERO_CURVE);
		send_target(32'sd5);
		wait_idle();
	endtask

	// Unsorted curve; a write past the last point must leave everything alone.
	task automatic test_unsorted_curve();
		logic [63:0] junk;
		int          k;
		junk = {$urandom, $urandom};
		write_reg(REG_OUT_OF_RANGE, junk[POINT_W-1:0]);
		random_registers(1'b0);
		for (k = 0; k < 25; k++)
			send_target(pick_target());
		wait_idle();
	endtask

	// Follow random targets under a series of random settings.
	task automatic test_random_following();
		int ph, k;
		for (ph = 0; ph < 7; ph++) begin
			wait_idle();
			idle_on = (ph != 3) && (ph != 6);
			random_registers(ph % 3 != 2);
			for (k = 0; k < 55; k++) begin
				if (ph == 1 && k == 27)
					wait_idle();
				send_target(pick_target());
			end
		end
		wait_idle();
	endtask

	// Result side: random stall bursts while idling is on.
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin : check_results
		tick_t got, want;
		logic  bad;
		int    p;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.position = result_ch.position;
			got.phase_index = result_ch.phase_index;
			got.duty[0] = result_ch.duty_a;
			got.duty[1] = result_ch.duty_b;
			got.duty[2] = result_ch.duty_c;
			got.duty[3] = result_ch.duty_d;
			got.duty[4] = result_ch.duty_e;
			if (expected_ticks.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result word with nothing expected", $realtime);
			end else begin
				want = expected_ticks.pop_front();
				bad = (got.position !== want.position) || (got.phase_index !== want.phase_index);
				for (p = 0; p < PHASES; p++)
					bad = bad || (got.duty[p] !== want.duty[p]);
				if (bad) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: expected pos %0d idx %0d duty %h, got pos %0d idx %0d duty %h",
							$realtime, want.position, want.phase_index, want.duty,
							got.position, got.phase_index, got.duty);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.target_count <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_curve_segments();
		test_fractional_moves();
		test_register_extremes();
		test_unsorted_curve();
		test_random_following();

		// Let any stray result word show up before the verdict.
		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_ticks.size() == 0)
			$display("[five_phase_stepper_follower] OK");
		else
			$display("[five_phase_stepper_follower] ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("[five_phase_stepper_follower] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/fpsf_pkg.sv
hw/rtl/fpsf_if.sv
hw/rtl/five_phase_stepper_follower.sv
dv/tb_top.sv
